// ----- rtl/mbag_pkg.sv -----
`timescale 1ns / 1ps
package mbag_pkg;

	localparam int DEPTH_DEF      = 256;
	localparam int ITEM_WIDTH_DEF = 32;
	localparam int VALUE_W        = 32;
	localparam int CFG_W          = 9;
	localparam int CNT_OUT_W      = 9;
	localparam int CAP_RESET      = 16;

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_COUNT  = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

endpackage

// ----- rtl/mbag_if.sv -----
`timescale 1ns / 1ps
interface mbag_req_if;
	logic                          valid;
	logic                          ready;
	mbag_pkg::mode_t               mode;
	logic [mbag_pkg::VALUE_W-1:0]  item_value;

	modport source (output valid, output mode, output item_value, input ready);
	modport sink   (input valid, input mode, input item_value, output ready);
endinterface

interface mbag_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            op_flag;
	logic                            rejected;
	logic [mbag_pkg::CNT_OUT_W-1:0]  frequency;
	logic                            found;
	logic [mbag_pkg::CNT_OUT_W-1:0]  item_count;
	logic [mbag_pkg::CNT_OUT_W-1:0]  capacity_now;
	logic                            empty_res;

	modport source (output valid, output op_flag, output rejected, output frequency,
		output found, output item_count, output capacity_now, output empty_res,
		input ready);
	modport sink (input valid, input op_flag, input rejected, input frequency,
		input found, input item_count, input capacity_now, input empty_res,
		output ready);
endinterface

// ----- rtl/mbag_mem.sv -----
`timescale 1ns / 1ps
module mbag_mem #(
	parameter int DEPTH      = 256,
	parameter int ITEM_WIDTH = 32,
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [ITEM_WIDTH-1:0] wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [ITEM_WIDTH-1:0] rdata
);

	logic [ITEM_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/multiset_bag_table_unit.sv -----
`timescale 1ns / 1ps
// Add and clear go from idle straight to the done state. Remove and count walk
// the stored entries through one memory read port, one per cycle; a remove that
// hits then reads the last entry and moves it into the freed slot. Each result is
// loaded into the output register from the done state. One request is in work at
// a time: a new one is taken only in idle, after the last result is loaded. Reset:
// item count 0, capacity 16 (clamped to DEPTH); entry memory is not cleared.
module multiset_bag_table_unit #(
	parameter int DEPTH      = mbag_pkg::DEPTH_DEF,
	parameter int ITEM_WIDTH = mbag_pkg::ITEM_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [mbag_pkg::CFG_W-1:0]  cfg_wdata,
	mbag_req_if.sink                    req,
	mbag_rsp_if.source                  rsp
);
	import mbag_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int CAP_RST = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_MOVE = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         cap_q;
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         freq_q;
	logic                  flag_q;
	logic                  rej_q;
	mode_t                 mode_q;
	logic [ITEM_WIDTH-1:0] val_q;
	logic [AW-1:0]         pos_q;
	logic                  rv_s1;
	logic [AW-1:0]         ra_s1;

	logic                  out_v_q;
	logic                  out_flag_q;
	logic                  out_rej_q;
	logic [CNT_OUT_W-1:0]  out_freq_q;
	logic                  out_found_q;
	logic [CNT_OUT_W-1:0]  out_cnt_q;
	logic [CNT_OUT_W-1:0]  out_cap_q;
	logic                  out_empty_q;

	logic [ITEM_WIDTH+VALUE_W-1:0] val_ext;
	logic [ITEM_WIDTH-1:0] val_in;
	logic                  accept;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [ITEM_WIDTH-1:0] wdata;
	logic                  re;
	logic [AW-1:0]         raddr;
	logic [ITEM_WIDTH-1:0] rdata;
	logic                  hit;
	logic                  last;
	logic                  issue;
	logic                  load_out;
	logic [CW:0]           cap_dbl;
	logic [CW-1:0]         cap_sat;
	logic [CW-1:0]         cap_cfg;
	logic [CW-1:0]         cnt_inc;
	logic [CW-1:0]         cnt_dec;

	assign val_ext = {{ITEM_WIDTH{1'b0}}, req.item_value};
	assign val_in  = val_ext[ITEM_WIDTH-1:0];
	assign req.ready = (state_q == ST_IDLE);
	assign accept  = req.valid && req.ready;

	assign cnt_inc = cnt_q + CW'(1);
	assign cnt_dec = cnt_q - CW'(1);
	assign cap_dbl = {cap_q, 1'b0};
	assign cap_sat = (cap_dbl > (CW + 1)'(DEPTH)) ? CW'(DEPTH) : cap_dbl[CW-1:0];

	always_comb begin
		if (cfg_wdata == '0) begin
			cap_cfg = CW'(1);
		end else if (int'(cfg_wdata) > DEPTH) begin
			cap_cfg = CW'(DEPTH);
		end else begin
			cap_cfg = CW'(cfg_wdata);
		end
	end

	assign hit   = rv_s1 && (rdata == val_q);
	assign last  = rv_s1 && (CW'(ra_s1) == cnt_dec);
	assign issue = idx_q < cnt_q;

	// write port: append on add, fill the freed slot on a remove hit
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = val_in;
		if (state_q == ST_MOVE) begin
			we    = 1'b1;
			waddr = pos_q;
			wdata = rdata;
		end else if (accept && req.mode == MODE_ADD && cnt_q != CW'(DEPTH)) begin
			we = 1'b1;
		end
	end

	// read port: walk entries, or fetch the last entry once a remove hits
	always_comb begin
		re    = 1'b0;
		raddr = idx_q[AW-1:0];
		if (state_q == ST_SCAN) begin
			if (mode_q == MODE_REMOVE && hit) begin
				re    = 1'b1;
				raddr = cnt_dec[AW-1:0];
			end else begin
				re = issue;
			end
		end
	end

	mbag_mem #(
		.DEPTH      (DEPTH),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign load_out = (state_q == ST_DONE) && (!out_v_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			cap_q   <= CW'(CAP_RST);
			rv_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cap_cfg;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DONE;
						case (req.mode) inside
							MODE_ADD: begin
								if (cnt_q != CW'(DEPTH)) begin
									cnt_q <= cnt_inc;
									if (cnt_q >= cap_q) begin
										cap_q <= cap_sat;
									end
								end
							end
							MODE_REMOVE, MODE_COUNT: begin
								if (cnt_q != '0) begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
								cnt_q <= '0;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (mode_q == MODE_REMOVE && hit) begin
						rv_s1   <= 1'b0;
						state_q <= ST_MOVE;
					end else begin
						rv_s1 <= issue;
						if (last) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_MOVE: begin
					cnt_q   <= cnt_dec;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers of the current request
	always_ff @(posedge clk) begin
		ra_s1 <= idx_q[AW-1:0];
		if (accept) begin
			mode_q <= req.mode;
			val_q  <= val_in;
			idx_q  <= '0;
			freq_q <= '0;
			rej_q  <= (req.mode == MODE_ADD) && (cnt_q == CW'(DEPTH));
			flag_q <= (req.mode == MODE_ADD) && (cnt_q != CW'(DEPTH)) &&
				(cnt_q < cap_q) && (cnt_inc >= cap_q);
		end else if (state_q == ST_SCAN) begin
			if (mode_q == MODE_REMOVE && hit) begin
				pos_q  <= ra_s1;
				flag_q <= 1'b1;
			end else begin
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
				if (mode_q == MODE_COUNT && hit) begin
					freq_q <= freq_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_flag_q  <= flag_q;
			out_rej_q   <= rej_q;
			out_freq_q  <= CNT_OUT_W'(freq_q);
			out_found_q <= (freq_q != '0);
			out_cnt_q   <= CNT_OUT_W'(cnt_q);
			out_cap_q   <= CNT_OUT_W'(cap_q);
			out_empty_q <= (cnt_q == '0);
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.op_flag      = out_flag_q;
	assign rsp.rejected     = out_rej_q;
	assign rsp.frequency    = out_freq_q;
	assign rsp.found        = out_found_q;
	assign rsp.item_count   = out_cnt_q;
	assign rsp.capacity_now = out_cap_q;
	assign rsp.empty_res    = out_empty_q;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import mbag_pkg::*;

	localparam int BAG_DEPTH   = DEPTH_DEF;
	localparam int STALL_LIMIT = 20000;
	localparam int POOL_SIZE   = 6;

	typedef struct packed {
		logic                 op_flag;
		logic                 rejected;
		logic [CNT_OUT_W-1:0] frequency;
		logic                 found;
		logic [CNT_OUT_W-1:0] item_count;
		logic [CNT_OUT_W-1:0] capacity_now;
		logic                 empty_res;
	} bag_result_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	mbag_req_if req_bus ();
	mbag_rsp_if rsp_bus ();

	multiset_bag_table_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_bus),
		.rsp       (rsp_bus)
	);

	// shadow of the bag contents and capacity
	logic [VALUE_W-1:0] bag_entries [0:BAG_DEPTH-1];
	int                 bag_count;
	int                 bag_cap;
	bag_result_t        pending_results [$];
	logic [VALUE_W-1:0] value_pool [0:POOL_SIZE-1];

	int error_count = 0;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("Verification failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic int clamp_cap(input int c);
		if (c < 1)
			return 1;
		if (c > BAG_DEPTH)
			return BAG_DEPTH;
		return c;
	endfunction

	function automatic bag_result_t apply_request(input mode_t m, input logic [VALUE_W-1:0] v);
		bag_result_t r;
		int          freq;
		r = '0;
		freq = 0;
		case (m)
			MODE_ADD: begin
				if (bag_count >= BAG_DEPTH) begin
					r.rejected = 1'b1;
				end else if (bag_count >= bag_cap) begin
					// capacity doubles first, no full flag in that case
					bag_cap = (bag_cap * 2 > BAG_DEPTH) ? BAG_DEPTH : bag_cap * 2;
					bag_entries[bag_count] = v;
					bag_count++;
				end else begin
					bag_entries[bag_count] = v;
					bag_count++;
					r.op_flag = (bag_count >= bag_cap);
				end
			end
			MODE_REMOVE: begin
				for (int i = 0; i < bag_count; i++) begin
					if (!r.op_flag && bag_entries[i] == v) begin
						bag_count--;
						bag_entries[i] = bag_entries[bag_count];
						r.op_flag = 1'b1;
					end
				end
			end
			MODE_COUNT: begin
				for (int i = 0; i < bag_count; i++)
					if (bag_entries[i] == v)
						freq++;
				r.frequency = CNT_OUT_W'(freq);
				r.found     = (freq > 0);
			end
			default: begin
				bag_count = 0;
			end
		endcase
		r.item_count   = CNT_OUT_W'(bag_count);
		r.capacity_now = CNT_OUT_W'(bag_cap);
		r.empty_res    = (bag_count == 0);
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		bag_result_t got;
		bag_result_t want;
		if (rsp_bus.valid && rsp_bus.ready) begin
			got.op_flag      = rsp_bus.op_flag;
			got.rejected     = rsp_bus.rejected;
			got.frequency    = rsp_bus.frequency;
			got.found        = rsp_bus.found;
			got.item_count   = rsp_bus.item_count;
			got.capacity_now = rsp_bus.capacity_now;
			got.empty_res    = rsp_bus.empty_res;
			if (pending_results.size() == 0) begin
				report_mismatch("result transaction with none expected");
			end else begin
				want = pending_results.pop_front();
				if (got.op_flag !== want.op_flag)
					report_mismatch($sformatf("op_flag %b, expected %b",
						got.op_flag, want.op_flag));
				if (got.rejected !== want.rejected)
					report_mismatch($sformatf("rejected %b, expected %b",
						got.rejected, want.rejected));
				if (got.frequency !== want.frequency)
					report_mismatch($sformatf("frequency %0d, expected %0d",
						got.frequency, want.frequency));
				if (got.found !== want.found)
					report_mismatch($sformatf("found %b, expected %b",
						got.found, want.found));
				if (got.item_count !== want.item_count)
					report_mismatch($sformatf("item_count %0d, expected %0d",
						got.item_count, want.item_count));
				if (got.capacity_now !== want.capacity_now)
					report_mismatch($sformatf("capacity_now %0d, expected %0d",
						got.capacity_now, want.capacity_now));
				if (got.empty_res !== want.empty_res)
					report_mismatch($sformatf("empty_res %b, expected %b",
						got.empty_res, want.empty_res));
			end
		end
	end

	// Called at a falling edge; returns at a falling edge with valid still high.
	task automatic send_request(input mode_t m, input logic [VALUE_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid      <= 1'b1;
		req_bus.mode       <= m;
		req_bus.item_value <= v;
		do
			@(posedge clk);
		while (!req_bus.ready);
		pending_results = {pending_results, apply_request(m, v)};
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		// quiet gap between phases
		repeat (4) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		bag_cap = clamp_cap(int'(v));
	endtask

	task automatic refresh_pool();
		for (int i = 0; i < POOL_SIZE; i++) begin
			case ($urandom_range(7))
				0: value_pool[i] = '0;
				1: value_pool[i] = '1;
				default: value_pool[i] = $urandom;
			endcase
		end
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		if ($urandom_range(9) < 8)
			return value_pool[$urandom_range(POOL_SIZE - 1)];
		return $urandom;
	endfunction

	task automatic test_basic_ops();
		send_request(MODE_COUNT, '0);
		send_request(MODE_REMOVE, '0);
		send_request(MODE_ADD, '0);
		send_request(MODE_ADD, '1);
		send_request(MODE_ADD, 32'h5A5A_5A5A);
		send_request(MODE_COUNT, '1);
		send_request(MODE_COUNT, '0);
		send_request(MODE_REMOVE, '1);
		send_request(MODE_COUNT, 32'h5A5A_5A5A);
		send_request(MODE_REMOVE, '0);
		send_request(MODE_REMOVE, 32'h5A5A_5A5A);
		send_request(MODE_COUNT, 32'h5A5A_5A5A);
		send_request(MODE_ADD, 32'hA5A5_A5A5);
		send_request(MODE_ADD, 32'hA5A5_A5A5);
		send_request(MODE_COUNT, 32'hA5A5_A5A5);
		send_request(MODE_CLEAR, '1);
		send_request(MODE_COUNT, 32'hA5A5_A5A5);
	endtask

	task automatic test_capacity_edges();
		drain_results();
		write_capacity('0);         // zero loads as one
		for (int i = 0; i < 4; i++)
			send_request(MODE_ADD, 32'h0000_0100 + i);
		drain_results();
		write_capacity(9'd1);       // capacity now below the stored count
		send_request(MODE_ADD, 32'h1234_5678);
		send_request(MODE_ADD, 32'h1234_5678);
		send_request(MODE_REMOVE, 32'h0000_0101);
		send_request(MODE_CLEAR, '0);
		drain_results();
		write_capacity(9'd257);
		write_capacity('1);
		send_request(MODE_ADD, 32'hFFFF_0000);
		drain_results();
		write_capacity(9'd256);
		send_request(MODE_ADD, 32'h0000_FFFF);
		send_request(MODE_CLEAR, '0);
	endtask

	task automatic test_full_store();
		drain_results();
		refresh_pool();
		write_capacity(9'd3);       // 3..192 then saturates at the depth
		for (int i = 0; i < BAG_DEPTH; i++)
			send_request(MODE_ADD, pick_value());
		send_request(MODE_ADD, pick_value());
		send_request(MODE_COUNT, value_pool[0]);
		send_request(MODE_REMOVE, $urandom);
		send_request(MODE_REMOVE, value_pool[1]);
		send_request(MODE_ADD, value_pool[2]);
		send_request(MODE_ADD, value_pool[3]);
		send_request(MODE_COUNT, value_pool[2]);
		send_request(MODE_CLEAR, '0);
	endtask

	task automatic test_random_mix(input int n_items);
		int pick;
		drain_results();
		refresh_pool();
		write_capacity($urandom_range(1) ? CFG_W'($urandom_range(1, 8))
			: CFG_W'($urandom_range(0, 511)));
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				send_request(MODE_ADD, pick_value());
			else if (pick < 70)
				send_request(MODE_REMOVE, pick_value());
			else if (pick < 97)
				send_request(MODE_COUNT, pick_value());
			else
				send_request(MODE_CLEAR, $urandom);
			if ($urandom_range(99) == 0)
				drain_results();
		end
	endtask

	task automatic finish_run();
		drain_results();
		repeat (BAG_DEPTH + 8) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		req_bus.valid      = 1'b0;
		req_bus.mode       = MODE_ADD;
		req_bus.item_value = '0;
		bag_count          = 0;
		bag_cap            = clamp_cap(CAP_RESET);
		send_idle_pct      = 25;
		recv_idle_pct      = 74;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_basic_ops();
		test_capacity_edges();
		test_full_store();
		test_random_mix(370);

		send_idle_pct = 74;
		recv_idle_pct = 25;
		test_random_mix(370);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_mix(370);

		finish_run();
	end

endmodule
